@@ hdl/cba_pkg.sv @@
// Shared types and constants for the channel bitmap allocator.
package cba_pkg;

    // Fixed field widths of the request and response items
    localparam int OP_W     = 1;
    localparam int LINK_IDW = 4;
    localparam int QUANT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 6;
    localparam int CFG_W    = 7;

    // Upper bound on responses for a single request
    localparam int MAX_RESULTS = 16;

    // Reset value of the scan limit register
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ATTACHED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HOLDING      = 2'd2;

    // Request item
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [LINK_IDW-1:0] link_id;
        logic [QUANT_W-1:0]  quantum;
        logic                link_attached;
    } req_t;

    // Response item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                channel_valid;
        logic [IDX_W-1:0]    channel_index;
        logic                last;
    } rsp_t;

endpackage

@@ hdl/cba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/channel_bitmap_allocator.sv @@
// First-fit channel allocator: busy flags, per-link channel lists and counts.
// Sequence: a refused request loads its one item in S_REPLY once the output is
//   free; an allocate scans one channel per cycle unless a grant waits on the output.
// Release: per held channel, a list RAM read, then a flag clear.
// Requests are taken one at a time; ready again once the last item is loaded.
// Reset clears busy flags and link counts at once; the list RAM is not cleared.
module channel_bitmap_allocator #(
    parameter int NUM_CHANNELS = 64,
    parameter int LINK_SLOTS   = 16,
    parameter int NUM_LINKS    = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  cba_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output cba_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cba_pkg::CFG_W-1:0] cfg_data
);

    localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_CNT_W   = $clog2(NUM_CHANNELS + 1);
    localparam int LINK_W     = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam int CNT_W      = $clog2(LINK_SLOTS + 1);
    localparam int LIST_DEPTH = NUM_LINKS * LINK_SLOTS;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int WANT_W     = $clog2(cba_pkg::MAX_RESULTS + 1);
    localparam int WANT_MAX   = (LINK_SLOTS < cba_pkg::MAX_RESULTS) ?
                                LINK_SLOTS : cba_pkg::MAX_RESULTS;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_FLUSH    = 3'd2;
    localparam logic [2:0] S_REL_RD   = 3'd3;
    localparam logic [2:0] S_REL_FREE = 3'd4;
    localparam logic [2:0] S_REPLY    = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [cba_pkg::CFG_W-1:0]      cfg_reg;
    logic [NUM_CHANNELS-1:0]        busy_reg;
    logic [CNT_W-1:0]               cnt_reg [NUM_LINKS];
    logic [LINK_W-1:0]              link_reg, link_next;
    logic [ADDR_W-1:0]              base_reg, base_next;
    logic [WANT_W-1:0]              want_reg, want_next;
    logic [WANT_W-1:0]              got_reg, got_next;
    logic [CH_CNT_W-1:0]            ch_reg, ch_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [CH_W-1:0]                pend_ch_reg, pend_ch_next;
    logic [CNT_W-1:0]               n_reg, n_next;
    logic [CNT_W-1:0]               slot_reg, slot_next;
    logic [cba_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           rsp_valid_reg;
    cba_pkg::rsp_t                  rsp_reg, rsp_next;

    logic                           rsp_load;
    logic                           out_free;
    logic                           busy_set, busy_clr;
    logic                           cnt_we;
    logic [CNT_W-1:0]               cnt_wdata;
    logic                           ram_we, ram_re;
    logic [ADDR_W-1:0]              ram_waddr, ram_raddr;
    logic [CH_W-1:0]                ram_rdata;
    logic [CH_W-1:0]                ch_idx;
    logic [LINK_W-1:0]              link_idx;
    logic                           link_ok;
    logic                           scan_go;
    int                             want_int;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign ch_idx    = ch_reg[CH_W-1:0];
    assign link_idx  = LINK_W'(req.link_id);
    assign link_ok   = req.link_attached && (32'(req.link_id) < NUM_LINKS);
    assign scan_go   = (32'(ch_reg) < 32'(cfg_reg)) && (32'(ch_reg) < NUM_CHANNELS)
                       && (got_reg < want_reg);
    assign ram_waddr = ADDR_W'(32'(base_reg) + 32'(got_reg));
    assign ram_raddr = ADDR_W'(32'(base_reg) + 32'(slot_reg));

    // Quantum clamp: zero acts as one, saturate at slots and result limit
    always_comb
    begin
        want_int = (req.quantum == '0) ? 1 : 32'(req.quantum);
        if (want_int > WANT_MAX)
        begin
            want_int = WANT_MAX;
        end
    end

    // Channel list storage, one row of LINK_SLOTS entries per link
    cba_ram #(
        .WIDTH (CH_W),
        .DEPTH (LIST_DEPTH)
    ) u_list (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ch_idx),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Sequencer next-state and strobes
    always_comb
    begin
        state_next      = state_reg;
        link_next       = link_reg;
        base_next       = base_reg;
        want_next       = want_reg;
        got_next        = got_reg;
        ch_next         = ch_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        n_next          = n_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        rsp_load        = 1'b0;
        rsp_next        = rsp_reg;
        busy_set        = 1'b0;
        busy_clr        = 1'b0;
        cnt_we          = 1'b0;
        cnt_wdata       = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    link_next       = link_idx;
                    base_next       = ADDR_W'(32'(link_idx) * LINK_SLOTS);
                    want_next       = WANT_W'(want_int);
                    got_next        = '0;
                    ch_next         = '0;
                    pend_valid_next = 1'b0;
                    slot_next       = '0;
                    n_next          = cnt_reg[link_idx];
                    if (!link_ok)
                    begin
                        status_next = cba_pkg::STATUS_NOT_ATTACHED;
                        state_next  = S_REPLY;
                    end
                    else if (req.op == cba_pkg::OP_RELEASE)
                    begin
                        state_next = S_REL_RD;
                    end
                    else if (cnt_reg[link_idx] != '0)
                    begin
                        status_next = cba_pkg::STATUS_HOLDING;
                        state_next  = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // One channel per cycle unless a grant waits on the output; a grant pushes the previous grant out
            S_SCAN:
            begin
                if (scan_go)
                begin
                    if (busy_reg[ch_idx])
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        busy_set = 1'b1;
                        ram_we   = 1'b1;
                        if (pend_valid_reg)
                        begin
                            rsp_load               = 1'b1;
                            rsp_next.status        = cba_pkg::STATUS_OK;
                            rsp_next.channel_valid = 1'b1;
                            rsp_next.channel_index = cba_pkg::IDX_W'(pend_ch_reg);
                            rsp_next.last          = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_ch_next    = ch_idx;
                        got_next        = got_reg + 1'b1;
                        ch_next         = ch_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end

            // Final item of an allocate, and commit the link's count
            S_FLUSH:
            begin
                if (out_free)
                begin
                    rsp_load               = 1'b1;
                    rsp_next.status        = cba_pkg::STATUS_OK;
                    rsp_next.channel_valid = pend_valid_reg;
                    rsp_next.channel_index = pend_valid_reg ?
                                             cba_pkg::IDX_W'(pend_ch_reg) : '0;
                    rsp_next.last          = 1'b1;
                    cnt_we                 = 1'b1;
                    cnt_wdata              = CNT_W'(got_reg);
                    state_next             = S_IDLE;
                end
            end

            S_REL_RD:
            begin
                if (slot_reg < n_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = S_REL_FREE;
                end
                else
                begin
                    cnt_we      = 1'b1;
                    cnt_wdata   = '0;
                    status_next = cba_pkg::STATUS_OK;
                    state_next  = S_REPLY;
                end
            end

            S_REL_FREE:
            begin
                busy_clr   = (32'(ram_rdata) < NUM_CHANNELS);
                slot_next  = slot_reg + 1'b1;
                state_next = S_REL_RD;
            end

            // Single item with no channel
            S_REPLY:
            begin
                if (out_free)
                begin
                    rsp_load               = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.channel_valid = 1'b0;
                    rsp_next.channel_index = '0;
                    rsp_next.last          = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_reg        <= cba_pkg::CFG_RESET;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            busy_reg       <= '0;
            for (int i = 0; i < NUM_LINKS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (busy_set)
            begin
                busy_reg[ch_idx] <= 1'b1;
            end
            if (busy_clr)
            begin
                busy_reg[ram_rdata] <= 1'b0;
            end
            if (cnt_we)
            begin
                cnt_reg[link_reg] <= cnt_wdata;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        link_reg    <= link_next;
        base_reg    <= base_next;
        want_reg    <= want_next;
        got_reg     <= got_next;
        ch_reg      <= ch_next;
        pend_ch_reg <= pend_ch_next;
        n_reg       <= n_next;
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTH
    // Output register is only loaded when it is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> out_free)
        else $error("response register overwritten");

    // Grants never exceed the clamped quantum
    a_got_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (got_reg <= want_reg))
        else $error("grant count above quantum");

    // Scan pointer stays within the channel range
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(ch_reg) <= NUM_CHANNELS))
        else $error("scan pointer out of range");

    // A granted channel is marked busy the cycle after the grant
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_set |=> busy_reg[$past(ch_idx)])
        else $error("granted channel not marked busy");

    // Items carrying a channel always report success
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.channel_valid) |-> (rsp.status == cba_pkg::STATUS_OK))
        else $error("channel granted with error status");
`endif

endmodule
